// ===== rtl/mqup_pkg.sv =====
// shared types and constants of the quota usage parser
// no dependencies
package mqup_pkg;

  localparam int unsigned SizeBits  = 48;
  localparam int unsigned CountBits = 32;
  localparam int unsigned LineBits  = 16;
  localparam int unsigned PctBits   = 7;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChSize    = 8'h53;
  localparam logic [7:0] ChCount   = 8'h43;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChNewline = 8'h0a;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusHdrErr  = 2'd1;
  localparam logic [1:0] StatusNoLines = 2'd2;

  localparam logic CfgExtraSize  = 1'b0;
  localparam logic CfgExtraCount = 1'b1;

  // parse snapshot handed from the front to the back at end of file
  typedef struct packed {
    logic signed [SizeBits-1:0]  total_size;
    logic signed [CountBits-1:0] total_count;
    logic [LineBits-1:0]         total_lines;
    logic [SizeBits-1:0]         limit_size;
    logic [CountBits-1:0]        limit_count;
    logic                        header_error;
  } summary_t;

  typedef struct packed {
    logic signed [SizeBits-1:0]  used_size;
    logic signed [CountBits-1:0] used_count;
    logic [LineBits-1:0]         line_count;
    logic [SizeBits-1:0]         limit_size;
    logic [CountBits-1:0]        limit_count;
    logic [PctBits-1:0]          usage_percent;
    logic [1:0]                  status;
  } result_t;

endpackage

// ===== rtl/maildir_quota_usage_parser.sv =====
// top level of the quota usage parser: config registers, front, summary queue, back unit
// depends on mqup_pkg, mqup_front, mqup_back
//
// quota file bytes stream in on the slave side at one item per cycle while the
// input is not held off. the front parses the header spec and the body lines and
// keeps saturating totals; on the item flagged tlast it hands a summary to a
// two-entry queue. the back computes the usage percentage by an iterative decimal
// long division per file: it takes the summary, runs two ratios of one setup step
// and its division steps each, and then loads the output register; a ratio with a
// zero limit, a non-positive total or a full quota ends its division early.
// the result item then waits in the output register. input is held off while
// the queue is full, or holds one summary while the next one is being written.
module maildir_quota_usage_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [191:0] m_axis_tdata,  // used_size, used_count, line_count,
                                      // limit_size, limit_count, usage_percent, status
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import mqup_pkg::*;

  logic [31:0] extra_size_q;
  logic [15:0] extra_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_size_q <= '0;
      extra_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgExtraSize:  extra_size_q <= cfg_wdata_i;
        CfgExtraCount: extra_count_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic     fr_valid;
  summary_t fr_sum;

  // summary queue between front and back
  summary_t   q_mem [2];
  logic [1:0] q_cnt_q;
  logic       q_wp_q, q_rp_q;
  logic       bk_ready;
  logic       q_pop;

  assign s_axis_tready = (q_cnt_q < 2'd2) && !(q_cnt_q == 2'd1 && fr_valid);
  assign q_pop = (q_cnt_q != 2'd0) && bk_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0; q_wp_q <= 1'b0; q_rp_q <= 1'b0;
    end else begin
      if (fr_valid) q_wp_q <= !q_wp_q;
      if (q_pop) q_rp_q <= !q_rp_q;
      q_cnt_q <= q_cnt_q + {1'b0, fr_valid} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_valid) q_mem[q_wp_q] <= fr_sum;
  end

  mqup_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid && s_axis_tready),
    .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .sum_valid_o(fr_valid), .sum_o(fr_sum)
  );

  result_t res;
  mqup_back u_back (
    .clk_i, .rst_ni,
    .sum_valid_i(q_cnt_q != 2'd0), .sum_ready_o(bk_ready), .sum_i(q_mem[q_rp_q]),
    .extra_size_i(extra_size_q), .extra_count_i(extra_count_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res.status, res.usage_percent, res.limit_count,
                         res.limit_size, res.line_count, res.used_count, res.used_size};

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.usage_percent <= 7'd100) else $error("percent out of range");
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= 2'd2) else $error("summary queue overflow");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.status != 2'd3) else $error("bad status code");

endmodule

// ===== rtl/mqup_front.sv =====
// byte parser: header spec and body lines, running totals
// depends on mqup_pkg
module mqup_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic                sum_valid_o,
  output mqup_pkg::summary_t  sum_o
);
  import mqup_pkg::*;

  localparam logic [SizeBits-1:0]  SizeMax  = {SizeBits{1'b1}};
  localparam logic [SizeBits-1:0]  SSizeMax = {1'b0, {(SizeBits-1){1'b1}}};
  localparam logic [SizeBits-1:0]  SCntMax  = {{(SizeBits-CountBits+1){1'b0}},
                                               {(CountBits-1){1'b1}}};
  localparam logic [SizeBits-1:0]  CntMax   = {{(SizeBits-CountBits){1'b0}},
                                               {CountBits{1'b1}}};

  logic                  in_header_q;
  logic [SizeBits-1:0]   acc_q;
  logic                  have_q, neg_q;
  logic                  field_q;
  logic [1:0]            space_q;
  logic                  nonempty_q;
  logic [1:0]            phase_q;
  logic signed [SizeBits-1:0]  psize_q;
  logic                  psize_ok_q;
  logic signed [SizeBits-1:0]  tsize_q;
  logic signed [CountBits-1:0] tcount_q;
  logic [LineBits-1:0]   lines_q;
  logic [SizeBits-1:0]   qsize_q;
  logic [CountBits-1:0]  qcount_q;
  logic                  herr_q;

  logic                  is_digit;
  logic [3:0]            dval;
  logic [SizeBits-1:0]   cap;
  logic [SizeBits+3:0]   acc_x10;
  logic [SizeBits-1:0]   acc_next;
  logic signed [SizeBits-1:0] fval;
  logic signed [SizeBits+1:0] ssum;
  logic signed [CountBits+1:0] csum;
  logic signed [CountBits-1:0] fcnt;
  logic                  end_line;
  logic                  do_add;

  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign dval     = byte_i[3:0];
  assign cap      = in_header_q ? SizeMax : (field_q ? SCntMax : SSizeMax);
  assign acc_x10  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {{SizeBits{1'b0}}, dval};
  assign acc_next = (acc_x10 > {4'b0000, cap}) ? cap : acc_x10[SizeBits-1:0];
  assign fval     = neg_q ? -$signed(acc_q) : $signed(acc_q);
  assign fcnt     = fval[CountBits-1:0];

  // a body line closes on newline, or on the last byte if it holds text
  assign end_line = !in_header_q && ((byte_i == ChNewline) ||
                    (last_i && (byte_i != ChNewline)));
  assign do_add   = psize_ok_q && (space_q == 2'd1) && have_q && field_q;

  always_comb begin
    ssum = {{2{tsize_q[SizeBits-1]}}, tsize_q} + {{2{psize_q[SizeBits-1]}}, psize_q};
    csum = {{2{tcount_q[CountBits-1]}}, tcount_q} + {{2{fcnt[CountBits-1]}}, fcnt};
  end

  function automatic logic signed [SizeBits-1:0] sat_s(input logic signed [SizeBits+1:0] v);
    if (v > $signed({2'b00, SSizeMax})) sat_s = $signed(SSizeMax);
    else if (v < -$signed({2'b00, SSizeMax}) - 1) sat_s = $signed(~SSizeMax);
    else sat_s = v[SizeBits-1:0];
  endfunction

  function automatic logic signed [CountBits-1:0] sat_c(input logic signed [CountBits+1:0] v);
    if (v > $signed({3'b000, {(CountBits-1){1'b1}}})) sat_c = {1'b0, {(CountBits-1){1'b1}}};
    else if (v < -$signed({3'b000, {(CountBits-1){1'b1}}}) - 1)
      sat_c = {1'b1, {(CountBits-1){1'b0}}};
    else sat_c = v[CountBits-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q <= 1'b1;
      acc_q <= '0; have_q <= 1'b0; neg_q <= 1'b0; field_q <= 1'b0;
      space_q <= '0; nonempty_q <= 1'b0; phase_q <= '0;
      psize_q <= '0; psize_ok_q <= 1'b0;
      tsize_q <= '0; tcount_q <= '0; lines_q <= '0;
      qsize_q <= '0; qcount_q <= '0; herr_q <= 1'b0;
      sum_valid_o <= 1'b0;
    end else begin
      sum_valid_o <= 1'b0;
      if (valid_i) begin
        if (last_i) begin
          // final snapshot, then clear for the next file
          sum_valid_o <= 1'b1;
          sum_o.total_size  <= tsize_q;
          sum_o.total_count <= tcount_q;
          sum_o.total_lines <= lines_q;
          sum_o.limit_size  <= qsize_q;
          sum_o.limit_count <= qcount_q;
          sum_o.header_error <= herr_q;
          if (in_header_q) begin
            if (is_digit) begin
              sum_o.header_error <= 1'b1;
            end else if (have_q) begin
              if (byte_i == ChSize) sum_o.limit_size <= acc_q;
              else if (byte_i == ChCount)
                sum_o.limit_count <= (acc_q > CntMax) ? '1 : acc_q[CountBits-1:0];
              else sum_o.header_error <= 1'b1;
            end
          end else begin
            // finish the last line with this byte included
            if (byte_i == ChNewline || nonempty_q || 1'b1) begin
              if (lines_q != '1) sum_o.total_lines <= lines_q + 1'b1;
            end
            if (byte_i == ChSpace) begin
              if (space_q == 2'd0) sum_o.total_lines <= (lines_q != '1) ? lines_q + 1'b1 : lines_q;
            end else if (byte_i != ChNewline && space_q == 2'd1 && psize_ok_q) begin
              if ((have_q || (is_digit && phase_q != 2'd3))) begin
                // figure updated by this byte
                sum_o.total_size  <= sat_s(ssum);
                sum_o.total_count <= sat_c(
                  {{2{tcount_q[CountBits-1]}}, tcount_q} + (
                  (is_digit && phase_q != 2'd3) ?
                    (neg_q ? -$signed({2'b00, acc_next[CountBits-1:0]})
                           : $signed({2'b00, acc_next[CountBits-1:0]}))
                    : {{2{fcnt[CountBits-1]}}, fcnt}));
              end
            end else if (byte_i == ChNewline && do_add) begin
              sum_o.total_size  <= sat_s(ssum);
              sum_o.total_count <= sat_c(csum);
            end
          end
          in_header_q <= 1'b1;
          acc_q <= '0; have_q <= 1'b0; neg_q <= 1'b0; field_q <= 1'b0;
          space_q <= '0; nonempty_q <= 1'b0; phase_q <= '0;
          psize_ok_q <= 1'b0; psize_q <= '0;
          tsize_q <= '0; tcount_q <= '0; lines_q <= '0;
          qsize_q <= '0; qcount_q <= '0; herr_q <= 1'b0;
        end else if (in_header_q) begin
          if (is_digit) begin
            acc_q <= acc_next;
            have_q <= 1'b1;
          end else begin
            if (have_q) begin
              if (byte_i == ChSize) qsize_q <= acc_q;
              else if (byte_i == ChCount)
                qcount_q <= (acc_q > CntMax) ? '1 : acc_q[CountBits-1:0];
              else herr_q <= 1'b1;
            end
            acc_q <= '0; have_q <= 1'b0;
            if (byte_i == ChNewline) in_header_q <= 1'b0;
          end
        end else if (end_line) begin
          if (lines_q != '1) lines_q <= lines_q + 1'b1;
          if (do_add) begin
            tsize_q  <= sat_s(ssum);
            tcount_q <= sat_c(csum);
          end
          acc_q <= '0; have_q <= 1'b0; neg_q <= 1'b0; phase_q <= '0;
          field_q <= 1'b0; space_q <= '0; nonempty_q <= 1'b0; psize_ok_q <= 1'b0;
        end else begin
          nonempty_q <= 1'b1;
          if (byte_i == ChSpace) begin
            if (space_q == 2'd0) begin
              psize_ok_q <= have_q;
              psize_q <= fval;
              acc_q <= '0; have_q <= 1'b0; neg_q <= 1'b0; phase_q <= '0;
              field_q <= 1'b1;
              space_q <= 2'd1;
            end else begin
              space_q <= 2'd2;
            end
          end else if (phase_q == 2'd0 && byte_i == ChMinus) begin
            neg_q <= 1'b1;
            phase_q <= 2'd1;
          end else if (phase_q != 2'd3 && is_digit) begin
            acc_q <= acc_next;
            have_q <= 1'b1;
            phase_q <= 2'd2;
          end else begin
            phase_q <= 2'd3;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/mqup_back.sv =====
// percentage unit: iterative decimal long division of two ratios
// depends on mqup_pkg
module mqup_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sum_valid_i,
  output logic                sum_ready_o,
  input  mqup_pkg::summary_t  sum_i,
  input  logic [31:0]         extra_size_i,
  input  logic [15:0]         extra_count_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output mqup_pkg::result_t   res_o
);
  import mqup_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_DIV, ST_OUT} state_e;

  localparam int unsigned W = SizeBits + 1;

  state_e             state_q;
  summary_t           sum_q;
  logic [W-1:0]       t_q, lim_q, r_q, acc_q;
  logic [PctBits-1:0] pct_q, best_q, dig_q;
  logic [4:0]         step_q;
  logic               sel_q;
  logic               zero_q, full_q;

  logic signed [W:0]  tot_ext;
  logic [W-1:0]       lmr;
  logic [W-1:0]       acc_n;
  logic               ge;

  assign sum_ready_o = (state_q == ST_IDLE);

  // total plus extra, as an unsigned value when positive
  always_comb begin
    if (!sel_q)
      tot_ext = {{2{sum_q.total_size[SizeBits-1]}}, sum_q.total_size} +
                $signed({{(W-31){1'b0}}, extra_size_i});
    else
      tot_ext = $signed({{(W-CountBits+1){sum_q.total_count[CountBits-1]}},
                         sum_q.total_count}) + $signed({{(W-15){1'b0}}, extra_count_i});
  end

  assign lmr   = lim_q - r_q;
  assign ge    = (acc_q >= lmr);
  assign acc_n = ge ? acc_q - lmr : acc_q + r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_valid_o <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (sum_valid_i) begin
            sum_q <= sum_i;
            sel_q <= 1'b0;
            best_q <= '0;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          lim_q <= sel_q ? {{(W-CountBits){1'b0}}, sum_q.limit_count}
                         : {1'b0, sum_q.limit_size};
          zero_q <= (sel_q ? (sum_q.limit_count == '0) : (sum_q.limit_size == '0)) ||
                    (tot_ext <= 0);
          t_q <= tot_ext[W-1:0];
          r_q <= tot_ext[W-1:0];
          acc_q <= '0;
          dig_q <= '0;
          pct_q <= '0;
          step_q <= '0;
          full_q <= 1'b0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (step_q == 5'd0 && t_q >= lim_q) full_q <= 1'b1;
          if (zero_q || full_q || (step_q == 5'd0 && t_q >= lim_q) || step_q == 5'd20) begin
            if (!zero_q && (full_q || t_q >= lim_q)) begin
              if (best_q < 7'd100) best_q <= 7'd100;
            end else if (!zero_q && pct_q > best_q) begin
              best_q <= pct_q;
            end
            if (sel_q) state_q <= ST_OUT;
            else begin
              sel_q <= 1'b1;
              state_q <= ST_PREP;
            end
          end else begin
            step_q <= step_q + 5'd1;
            if (step_q == 5'd9) begin
              pct_q <= 7'(dig_q + (ge ? 1 : 0));
              dig_q <= '0;
              r_q <= acc_n;
              acc_q <= '0;
            end else if (step_q == 5'd19) begin
              pct_q <= 7'(pct_q * 10 + dig_q + (ge ? 1 : 0));
              acc_q <= acc_n;
            end else begin
              dig_q <= dig_q + (ge ? 7'd1 : 7'd0);
              acc_q <= acc_n;
            end
          end
        end
        ST_OUT: begin
          if (!res_valid_o || res_ready_i) begin
            res_valid_o <= 1'b1;
            res_o.used_size <= sum_q.total_size;
            res_o.used_count <= sum_q.total_count;
            res_o.line_count <= sum_q.total_lines;
            res_o.limit_size <= sum_q.limit_size;
            res_o.limit_count <= sum_q.limit_count;
            res_o.usage_percent <= best_q;
            res_o.status <= sum_q.header_error ? StatusHdrErr :
                            (sum_q.total_lines == '0 ? StatusNoLines : StatusOk);
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (res_valid_o && res_ready_i && state_q != ST_OUT) res_valid_o <= 1'b0;
    end
  end

endmodule

// ===== bench/tb_maildir_quota_usage_parser.sv =====
// self-checking bench for the quota usage parser: quota files in, usage summaries out
// depends on mqup_pkg and maildir_quota_usage_parser
module tb_maildir_quota_usage_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import mqup_pkg::*;

  localparam longint SizeMax  = 64'h0000_7fff_ffff_ffff;  // signed size maximum
  localparam longint CountMax = 64'h0000_0000_7fff_ffff;  // signed count maximum
  localparam longint unsigned SizeCap  = 64'h0000_ffff_ffff_ffff;
  localparam longint unsigned CountCap = 64'h0000_0000_ffff_ffff;

  // one summary as it leaves the block
  typedef struct {
    logic signed [47:0] used_size;
    logic signed [31:0] used_count;
    logic [15:0]        line_count;
    logic [47:0]        limit_size;
    logic [31:0]        limit_count;
    logic [6:0]         usage_percent;
    logic [1:0]         status;
  } usage_t;

  // directed stimulus, status and line count typed in where obvious
  typedef struct {
    logic [7:0]  b;
    bit          last;
    bit          chk;
    logic [1:0]  st;
    logic [15:0] ln;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;

  maildir_quota_usage_parser dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the parser state and the extra registers
  longint unsigned x_size, x_count;
  bit      p_hdr, p_dig, p_neg, p_nonempty, p_herr, p_size_ok, p_count_ok;
  int      p_field, p_spaces, p_phase;
  longint unsigned p_acc, p_qsize, p_qcount;
  longint  p_size, p_count, t_size, t_count;
  int      t_lines;

  usage_t  pending_usage[$];  // summaries still owed by the block
  int      fails = 0;
  int      snd_idle = 0, rcv_idle = 0;
  bit      hold_go = 1'b0;
  int      hold_cnt = 0;
  logic [7:0] fbuf[$];        // bytes of the file under construction

  function automatic void clr_field();
    p_acc = 0; p_dig = 0; p_neg = 0; p_phase = 0;
  endfunction

  function automatic void clr_file();
    p_hdr = 1; clr_field();
    p_field = 0; p_spaces = 0; p_nonempty = 0;
    p_size = 0; p_size_ok = 0; p_count = 0; p_count_ok = 0;
    t_size = 0; t_count = 0; t_lines = 0;
    p_qsize = 0; p_qcount = 0; p_herr = 0;
  endfunction

  function automatic longint unsigned add_digit(longint unsigned acc, int d,
                                                longint unsigned cap);
    if (acc > (cap - d) / 10) return cap;
    return acc * 10 + d;
  endfunction

  function automatic longint sat_sum(longint a, longint b, longint smax);
    if (b > 0 && a > smax - b) return smax;
    if (b < 0 && a < -smax - 1 - b) return -smax - 1;
    return a + b;
  endfunction

  function automatic longint signed_fig();
    return p_neg ? -longint'(p_acc) : longint'(p_acc);
  endfunction

  // two decimal digits of t/lim by shift-free long division, clamped at 100
  function automatic int pct_of(longint tot, longint unsigned extra,
                                longint unsigned lim);
    longint unsigned t, r, acc, mag;
    int res, dg;
    res = 0;
    if (tot >= 0) t = longint'(tot) + extra;
    else begin
      mag = longint'(-(tot + 1)) + 1;
      if (extra <= mag) return 0;
      t = extra - mag;
    end
    if (t >= lim) return 100;
    r = t;
    for (int k = 0; k < 2; k++) begin
      dg = 0; acc = 0;
      for (int i = 0; i < 10; i++) begin
        if (acc >= lim - r) begin
          acc -= lim - r; dg++;
        end else begin
          acc += r;
        end
      end
      res = res * 10 + dg;
      r = acc;
    end
    return res;
  endfunction

  function automatic void close_line(bit by_nl);
    if (by_nl || p_nonempty) begin
      if (t_lines < 65535) t_lines++;
      if (p_spaces == 1) begin
        p_count_ok = p_dig;
        p_count = signed_fig();
        if (p_size_ok && p_count_ok) begin
          t_size  = sat_sum(t_size, p_size, SizeMax);
          t_count = sat_sum(t_count, p_count, CountMax);
        end
      end
    end
    clr_field();
    p_field = 0; p_spaces = 0; p_nonempty = 0; p_size_ok = 0; p_count_ok = 0;
  endfunction

  // advance the shadow by one byte, returns 1 with a summary on the last byte
  function automatic bit quota_step(logic [7:0] c, bit last, output usage_t u);
    int ps, pc;
    ps = 0; pc = 0;
    if (p_hdr) begin
      if (c >= "0" && c <= "9") begin
        p_acc = add_digit(p_acc, c - "0", SizeCap);
        p_dig = 1;
      end else begin
        if (p_dig) begin
          if (c == ChSize) p_qsize = p_acc;
          else if (c == ChCount) p_qcount = (p_acc > CountCap) ? CountCap : p_acc;
          else p_herr = 1;
        end
        clr_field();
        if (c == ChNewline) p_hdr = 0;
      end
    end else if (c == ChNewline) begin
      close_line(1);
    end else begin
      p_nonempty = 1;
      if (c == ChSpace) begin
        if (p_spaces == 0) begin
          p_size_ok = p_dig; p_size = signed_fig();
          clr_field();
          p_field = 1; p_spaces = 1;
        end else begin
          p_spaces = 2;
        end
      end else if (p_phase == 0 && c == ChMinus) begin
        p_neg = 1; p_phase = 1;
      end else if (p_phase < 3 && c >= "0" && c <= "9") begin
        p_acc = add_digit(p_acc, c - "0", (p_field == 0) ? SizeMax : CountMax);
        p_dig = 1; p_phase = 2;
      end else begin
        p_phase = 3;
      end
    end
    if (!last) return 0;
    if (p_hdr) begin
      if (p_dig) p_herr = 1;
    end else if (c != ChNewline) begin
      close_line(0);
    end
    if (p_qsize != 0)  ps = pct_of(t_size, x_size, p_qsize);
    if (p_qcount != 0) pc = pct_of(t_count, x_count, p_qcount);
    u.used_size     = t_size[47:0];
    u.used_count    = t_count[31:0];
    u.line_count    = t_lines[15:0];
    u.limit_size    = p_qsize[47:0];
    u.limit_count   = p_qcount[31:0];
    u.usage_percent = (pc > ps) ? pc[6:0] : ps[6:0];
    u.status        = p_herr ? StatusHdrErr : (t_lines == 0 ? StatusNoLines : StatusOk);
    clr_file();
    return 1;
  endfunction

  function automatic void flag_bad(string what, longint unsigned want, longint unsigned got);
    fails++;
    if (fails <= 10)
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
  endfunction

  // input side: every accepted item feeds the shadow
  bit     row_chk;
  logic [1:0]  row_st;
  logic [15:0] row_ln;
  always @(posedge clk_i) begin
    usage_t u;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (quota_step(s_axis_tdata, s_axis_tlast, u)) begin
        pending_usage.push_back(u);
        if (row_chk) begin
          if (u.status != row_st) flag_bad("typed status", row_st, u.status);
          if (u.line_count != row_ln) flag_bad("typed lines", row_ln, u.line_count);
        end
      end
    end
  end

  // output side: compare each summary with the oldest one owed
  always @(posedge clk_i) begin
    usage_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_usage.size() == 0) begin
        flag_bad("unexpected item", 0, m_axis_tdata[63:0]);
      end else begin
        w = pending_usage.pop_front();
        if (m_axis_tdata[47:0] != w.used_size)
          flag_bad("used_size", w.used_size, m_axis_tdata[47:0]);
        if (m_axis_tdata[79:48] != w.used_count)
          flag_bad("used_count", w.used_count, m_axis_tdata[79:48]);
        if (m_axis_tdata[95:80] != w.line_count)
          flag_bad("line_count", w.line_count, m_axis_tdata[95:80]);
        if (m_axis_tdata[143:96] != w.limit_size)
          flag_bad("limit_size", w.limit_size, m_axis_tdata[143:96]);
        if (m_axis_tdata[175:144] != w.limit_count)
          flag_bad("limit_count", w.limit_count, m_axis_tdata[175:144]);
        if (m_axis_tdata[182:176] != w.usage_percent)
          flag_bad("usage_percent", w.usage_percent, m_axis_tdata[182:176]);
        if (m_axis_tdata[184:183] != w.status)
          flag_bad("status", w.status, m_axis_tdata[184:183]);
      end
    end
  end

  // receiver ready, with a long hold-off on request so the summary queue backs up
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgExtraSize) x_size = val;
    else x_count = val[15:0];
  endtask

  // sender stops and the block drains, including the division of a file in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_usage.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic put_digits(int n);
    repeat (n) fbuf.push_back(8'(8'h30 + $urandom_range(9)));
  endtask

  function automatic int digit_len(int longest);
    return ($urandom_range(9) == 0) ? $urandom_range(14, longest) : $urandom_range(1, 6);
  endfunction

  // one random quota file, mostly well formed, some noise and broken headers
  task automatic make_file();
    int r;
    fbuf.delete();
    repeat ($urandom_range(2)) begin
      put_digits(digit_len(21));
      r = $urandom_range(9);
      if (r < 4) fbuf.push_back(ChSize);
      else if (r < 8) fbuf.push_back(ChCount);
      else if (r == 8) fbuf.push_back(8'($urandom_range(255)));
      else fbuf.push_back(ChNewline);
      if ($urandom_range(1)) fbuf.push_back(",");
    end
    if ($urandom_range(14) == 0) put_digits(2);
    else fbuf.push_back(ChNewline);
    repeat ($urandom_range(8)) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(6)) fbuf.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(3) == 0) fbuf.push_back(ChMinus);
        put_digits(digit_len(20));
        if ($urandom_range(11) == 0) fbuf.push_back("x");
        if ($urandom_range(15) != 0) fbuf.push_back(ChSpace);
        if ($urandom_range(3) == 0) fbuf.push_back(ChMinus);
        if ($urandom_range(15) != 0) put_digits(digit_len(12));
        if ($urandom_range(15) == 0) fbuf.push_back(ChSpace);
      end
      fbuf.push_back(ChNewline);
    end
    if (fbuf.size() > 1 && fbuf[$] == ChNewline && $urandom_range(1)) void'(fbuf.pop_back());
  endtask

  row_t rows[] = '{
    '{ChNewline, 1'b1, 1'b1, StatusNoLines, 16'd0},  // bare newline: no body lines
    '{"5", 1'b0, 1'b0, StatusOk, 16'd0},
    '{"Q", 1'b1, 1'b1, StatusHdrErr, 16'd0},          // bad suffix in the spec
    '{"3", 1'b1, 1'b1, StatusHdrErr, 16'd0},          // digit run cut by end of file
    '{"7", 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChCount, 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChNewline, 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChMinus, 1'b0, 1'b0, StatusOk, 16'd0},
    '{"1", 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChSpace, 1'b0, 1'b0, StatusOk, 16'd0},
    '{"5", 1'b1, 1'b1, StatusOk, 16'd1},              // last line with no newline
    '{"2", 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChSize, 1'b0, 1'b0, StatusOk, 16'd0},
    '{"1", 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChSize, 1'b0, 1'b0, StatusOk, 16'd0},           // repeated size limit, last wins
    '{ChNewline, 1'b0, 1'b0, StatusOk, 16'd0},
    '{8'hff, 1'b0, 1'b0, StatusOk, 16'd0},
    '{8'h00, 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChNewline, 1'b0, 1'b0, StatusOk, 16'd0},
    '{"4", 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChSpace, 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChSpace, 1'b0, 1'b0, StatusOk, 16'd0},          // two spaces: line counted, figures not added
    '{"4", 1'b0, 1'b0, StatusOk, 16'd0},
    '{ChNewline, 1'b1, 1'b1, StatusOk, 16'd2}
  };

  initial begin
    int sent;
    x_size = 0; x_count = 0;
    clr_file();
    row_chk = 1'b0; row_st = '0; row_ln = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 3; p++) begin
      // phase 0 receiver sparse, phase 1 sender sparse, phase 2 full rate
      snd_idle = (p == 0) ? 32 : (p == 1) ? 85 : 0;
      rcv_idle = (p == 0) ? 85 : (p == 1) ? 32 : 0;
      if (p == 0) begin
        cfg_write(CfgExtraSize, 32'd0);
        cfg_write(CfgExtraCount, 32'd0);
        foreach (rows[i]) begin
          // typed values move at the edge, after the previous row is checked
          row_chk <= rows[i].chk; row_st <= rows[i].st; row_ln <= rows[i].ln;
          send_byte(rows[i].b, rows[i].last);
        end
        drain();
        row_chk <= 1'b0;
        hold_go = 1'b1;
      end else if (p == 1) begin
        cfg_write(CfgExtraSize, 32'hffff_ffff);
        cfg_write(CfgExtraCount, 32'h0000_ffff);
      end else begin
        cfg_write(CfgExtraSize, $urandom_range(5000));
        cfg_write(CfgExtraCount, $urandom_range(20));
      end
      sent = 0;
      while (sent < 630) begin
        make_file();
        foreach (fbuf[i]) send_byte(fbuf[i], i == fbuf.size() - 1);
        sent += fbuf.size();
      end
      drain();
    end
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
